>>> hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check, disabled while reset is asserted (active low)
`define I2CBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on the block clock and reset
`define I2CBS_ASSERT_CLK(lbl, prop, msg) `I2CBS_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

>>> hdl/i2cbs_pkg.sv
`timescale 1ns / 1ps

package i2cbs_pkg;

    // Default width of the prescale counter
    localparam int PrescaleWidthDef = 16;

    // Configuration write port
    localparam int CfgDataW  = 16;
    localparam int CfgIndexW = 2;

    // Register reset values
    localparam logic [15:0] TicksPerDelayRst = 16'd16;
    localparam logic [7:0]  AckTimeoutRst    = 8'd250;

    // Command codes carried with each tick
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WIPER = 3'd5
    } command_t;

    // Register indexes on the configuration port
    typedef enum logic [CfgIndexW-1:0] {
        REG_TICKS_PER_DELAY = 2'd0,
        REG_DEVICE_ADDR     = 2'd1,
        REG_WIPER_ADDR      = 2'd2,
        REG_ACK_TIMEOUT     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] ticks_per_delay;
        logic [7:0]  device_write_address;
        logic [7:0]  wiper_register_address;
        logic [7:0]  ack_timeout;
    } cfg_t;

    // One tick as it enters the sequencer
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       ack_after_read;
        logic       sda_sample;
    } item_t;

    // Line and status levels after one tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       op_done;
        logic [7:0] read_data;
        logic       ack_missing;
    } result_t;

endpackage

>>> hdl/i2cbs_cfg_regs.sv
`timescale 1ns / 1ps

module i2cbs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write_en,
    input  logic [i2cbs_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [i2cbs_pkg::CfgDataW-1:0]    cfg_write_data,
    output i2cbs_pkg::cfg_t                   cfg
);
    import i2cbs_pkg::*;

    cfg_t cfg_reg;

    // Register file, written with no wait state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_delay        <= TicksPerDelayRst;
            cfg_reg.device_write_address   <= '0;
            cfg_reg.wiper_register_address <= '0;
            cfg_reg.ack_timeout            <= AckTimeoutRst;
        end else if (cfg_write_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TICKS_PER_DELAY: cfg_reg.ticks_per_delay <= cfg_write_data;
                REG_DEVICE_ADDR:     cfg_reg.device_write_address <= cfg_write_data[7:0];
                REG_WIPER_ADDR:      cfg_reg.wiper_register_address <= cfg_write_data[7:0];
                REG_ACK_TIMEOUT:     cfg_reg.ack_timeout <= cfg_write_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/i2cbs_seq_core.sv
`timescale 1ns / 1ps

module i2cbs_seq_core #(
    parameter int PRESCALE_WIDTH = i2cbs_pkg::PrescaleWidthDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2cbs_pkg::cfg_t     cfg,
    input  logic                item_fire,
    input  i2cbs_pkg::item_t    item,
    output i2cbs_pkg::result_t  result
);
    import i2cbs_pkg::*;

    // Compare width wide enough for both the counter and the register
    localparam int CW = (PRESCALE_WIDTH > CfgDataW) ? PRESCALE_WIDTH : CfgDataW;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
        PH_TX_A, PH_TX_B, PH_TX_C, PH_TX_D, PH_ACK,
        PH_RD_A, PH_RD_B, PH_RD_C, PH_AK_A, PH_AK_B, PH_AK_C
    } phase_t;

    phase_t                    phase_reg, phase_next, enter_ph;
    logic [PRESCALE_WIDTH-1:0] unit_counter_reg, unit_counter_next, cnt_inc;
    logic [1:0]                units_left_reg, units_left_next;
    logic [3:0]                bit_count_reg, bit_count_next;
    logic [7:0]                shift_data_reg, shift_data_next;
    logic [7:0]                wait_count_reg, wait_count_next;
    logic [1:0]                byte_index_reg, byte_index_next;
    logic [7:0]                read_data_reg, read_data_next;
    logic                      error_flag_reg, error_flag_next;
    logic                      scl_reg, scl_next;
    logic                      sda_reg, sda_next;
    logic                      drive_reg, drive_next;
    logic                      wiper_op_reg, wiper_op_next;
    logic [7:0]                wiper_value_reg, wiper_value_next;
    logic                      done_next;
    logic                      do_enter;
    logic [CW-1:0]             tpd_ext, cap_ext, tpd_eff, cnt_inc_ext;

    // Effective prescale: zero acts as one, clamp to the counter range
    assign tpd_ext     = CW'(cfg.ticks_per_delay);
    assign cap_ext     = CW'({PRESCALE_WIDTH{1'b1}});
    assign tpd_eff     = (tpd_ext == '0) ? {{(CW-1){1'b0}}, 1'b1}
                       : ((tpd_ext > cap_ext) ? cap_ext : tpd_ext);
    assign cnt_inc     = unit_counter_reg + 1'b1;
    assign cnt_inc_ext = CW'(cnt_inc);

    // Next state for one tick: step expiry first, then entry actions
    always_comb begin
        phase_next        = phase_reg;
        unit_counter_next = unit_counter_reg;
        units_left_next   = units_left_reg;
        bit_count_next    = bit_count_reg;
        shift_data_next   = shift_data_reg;
        wait_count_next   = wait_count_reg;
        byte_index_next   = byte_index_reg;
        read_data_next    = read_data_reg;
        error_flag_next   = error_flag_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        drive_next        = drive_reg;
        wiper_op_next     = wiper_op_reg;
        wiper_value_next  = wiper_value_reg;
        done_next         = 1'b0;
        do_enter          = 1'b0;
        enter_ph          = PH_IDLE;

        if (item_fire) begin
            if (phase_reg != PH_IDLE) begin
                unit_counter_next = cnt_inc;
                if (cnt_inc_ext >= tpd_eff) begin
                    unit_counter_next = '0;
                    if (units_left_reg != 2'd0) begin
                        units_left_next = units_left_reg - 2'd1;
                    end else begin
                        // Delay of the current step has run out
                        unique case (phase_reg)
                            PH_ST_A: begin do_enter = 1'b1; enter_ph = PH_ST_B; end
                            PH_ST_B: begin
                                scl_next = 1'b0;
                                if (wiper_op_reg) begin
                                    byte_index_next = 2'd0;
                                    shift_data_next = cfg.device_write_address;
                                    do_enter        = 1'b1;
                                    enter_ph        = PH_TX_A;
                                end else begin
                                    phase_next    = PH_IDLE;
                                    wiper_op_next = 1'b0;
                                    done_next     = 1'b1;
                                end
                            end
                            PH_SP_A: begin do_enter = 1'b1; enter_ph = PH_SP_B; end
                            PH_SP_B: begin
                                sda_next      = 1'b1;
                                phase_next    = PH_IDLE;
                                wiper_op_next = 1'b0;
                                done_next     = 1'b1;
                            end
                            PH_TX_A: begin do_enter = 1'b1; enter_ph = PH_TX_B; end
                            PH_TX_B: begin do_enter = 1'b1; enter_ph = PH_TX_C; end
                            PH_TX_C: begin do_enter = 1'b1; enter_ph = PH_TX_D; end
                            PH_TX_D: begin
                                bit_count_next = bit_count_reg + 4'd1;
                                do_enter       = 1'b1;
                                enter_ph       = bit_count_next[3] ? PH_ACK : PH_TX_B;
                            end
                            PH_ACK: begin
                                if (!item.sda_sample) begin
                                    // Slave acknowledged
                                    scl_next = 1'b0;
                                    if (wiper_op_reg) begin
                                        do_enter = 1'b1;
                                        if (byte_index_reg < 2'd2) begin
                                            byte_index_next = byte_index_reg + 2'd1;
                                            shift_data_next = (byte_index_reg == 2'd0)
                                                            ? cfg.wiper_register_address
                                                            : wiper_value_reg;
                                            enter_ph        = PH_TX_A;
                                        end else begin
                                            enter_ph = PH_SP_A;
                                        end
                                    end else begin
                                        phase_next    = PH_IDLE;
                                        wiper_op_next = 1'b0;
                                        done_next     = 1'b1;
                                    end
                                end else if (wait_count_reg >= cfg.ack_timeout) begin
                                    // Timed out: flag it and close with a stop
                                    error_flag_next = 1'b1;
                                    wiper_op_next   = 1'b0;
                                    do_enter        = 1'b1;
                                    enter_ph        = PH_SP_A;
                                end else begin
                                    wait_count_next = wait_count_reg + 8'd1;
                                    units_left_next = 2'd0;
                                end
                            end
                            PH_RD_A: begin do_enter = 1'b1; enter_ph = PH_RD_B; end
                            PH_RD_B: begin do_enter = 1'b1; enter_ph = PH_RD_C; end
                            PH_RD_C: begin
                                bit_count_next = bit_count_reg + 4'd1;
                                do_enter       = 1'b1;
                                enter_ph       = bit_count_next[3] ? PH_AK_A : PH_RD_B;
                            end
                            PH_AK_A: begin do_enter = 1'b1; enter_ph = PH_AK_B; end
                            PH_AK_B: begin do_enter = 1'b1; enter_ph = PH_AK_C; end
                            PH_AK_C: begin
                                scl_next       = 1'b0;
                                read_data_next = shift_data_reg;
                                phase_next     = PH_IDLE;
                                wiper_op_next  = 1'b0;
                                done_next      = 1'b1;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
            end else begin
                // Idle: take a new command
                unique case (item.command)
                    CMD_START, CMD_WIPER: begin
                        wiper_op_next    = (item.command == CMD_WIPER);
                        wiper_value_next = item.data_byte;
                        do_enter         = 1'b1;
                        enter_ph         = PH_ST_A;
                    end
                    CMD_STOP: begin
                        wiper_op_next = 1'b0;
                        do_enter      = 1'b1;
                        enter_ph      = PH_SP_A;
                    end
                    CMD_WRITE: begin
                        wiper_op_next   = 1'b0;
                        shift_data_next = item.data_byte;
                        do_enter        = 1'b1;
                        enter_ph        = PH_TX_A;
                    end
                    CMD_READ: begin
                        wiper_op_next   = 1'b0;
                        wait_count_next = {7'd0, item.ack_after_read};
                        do_enter        = 1'b1;
                        enter_ph        = PH_RD_A;
                    end
                    default: ;
                endcase
            end
        end

        // Entry actions of the new step; one delay unit unless units_left is set here
        if (do_enter) begin
            phase_next        = enter_ph;
            unit_counter_next = '0;
            units_left_next   = 2'd0;
            unique case (enter_ph)
                PH_ST_A: begin
                    drive_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                    units_left_next = 2'd2;
                end
                PH_ST_B: sda_next = 1'b0;
                PH_SP_A: begin drive_next = 1'b1; sda_next = 1'b0; end
                PH_SP_B: begin scl_next = 1'b1; units_left_next = 2'd2; end
                PH_TX_A: begin drive_next = 1'b1; scl_next = 1'b0; bit_count_next = 4'd0; end
                PH_TX_B: begin
                    sda_next        = shift_data_next[7];
                    shift_data_next = {shift_data_next[6:0], 1'b0};
                end
                PH_TX_C: scl_next = 1'b1;
                PH_TX_D: scl_next = 1'b0;
                PH_ACK: begin
                    drive_next = 1'b0; sda_next = 1'b1; scl_next = 1'b1;
                    wait_count_next = 8'd0; error_flag_next = 1'b0;
                end
                PH_RD_A: begin drive_next = 1'b0; bit_count_next = 4'd0; shift_data_next = 8'd0; end
                PH_RD_B: scl_next = 1'b0;
                PH_RD_C: begin
                    scl_next        = 1'b1;
                    shift_data_next = {shift_data_next[6:0], item.sda_sample};
                end
                PH_AK_A: begin scl_next = 1'b0; drive_next = 1'b1; end
                PH_AK_B: sda_next = ~wait_count_next[0];
                PH_AK_C: scl_next = 1'b1;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // State and line registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            unit_counter_reg <= '0;
            units_left_reg   <= 2'd0;
            bit_count_reg    <= 4'd0;
            shift_data_reg   <= 8'd0;
            wait_count_reg   <= 8'd0;
            byte_index_reg   <= 2'd0;
            read_data_reg    <= 8'd0;
            error_flag_reg   <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            drive_reg        <= 1'b1;
            wiper_op_reg     <= 1'b0;
            wiper_value_reg  <= 8'd0;
        end else begin
            phase_reg        <= phase_next;
            unit_counter_reg <= unit_counter_next;
            units_left_reg   <= units_left_next;
            bit_count_reg    <= bit_count_next;
            shift_data_reg   <= shift_data_next;
            wait_count_reg   <= wait_count_next;
            byte_index_reg   <= byte_index_next;
            read_data_reg    <= read_data_next;
            error_flag_reg   <= error_flag_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
            drive_reg        <= drive_next;
            wiper_op_reg     <= wiper_op_next;
            wiper_value_reg  <= wiper_value_next;
        end
    end

    // Levels after this tick, captured by the output stage
    always_comb begin
        result.scl_out          = scl_next;
        result.sda_out          = sda_next;
        result.sda_drive_enable = drive_next;
        result.busy_res         = (phase_next != PH_IDLE);
        result.op_done          = done_next;
        result.read_data        = read_data_next;
        result.ack_missing      = error_flag_next;
    end

endmodule

>>> hdl/i2cbs_out_buf.sv
`timescale 1ns / 1ps

module i2cbs_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cbs_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cbs_pkg::result_t  out_data
);
    import i2cbs_pkg::*;

    result_t main_data_reg, skid_data_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    pop;

    assign pop      = main_valid_reg & out_ready;
    assign in_ready = ~skid_valid_reg;

    // Valid flags of the output register and the skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || pop) begin
                main_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

>>> hdl/i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------------
// s_ (tick) | in        | s_valid / s_ready     | command, data_byte, ack_after_read, sda_sample
// m_ (line) | out       | m_valid / m_ready     | scl/sda levels, drive, busy, done, data, flag
// cfg_      | in        | cfg_write_en          | cfg_index, cfg_write_data
//
// One tick per clock while s_ready is high: a transfer on s_ updates the sequencer
// and its result is registered in the output stage. Reset (aresetn low, synchronous)
// gives idle, SCL and SDA high, SDA driven. A two-entry output stage keeps s_ready
// high while one result waits; s_ready drops only when both entries are full.
`include "assert_macros.svh"

module i2c_master_bit_sequencer_unit #(
    parameter int PRESCALE_WIDTH = i2cbs_pkg::PrescaleWidthDef
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_write_en,
    input  logic [i2cbs_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [i2cbs_pkg::CfgDataW-1:0]   cfg_write_data,
    // tick input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_command,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_ack_after_read,
    input  logic                             s_sda_sample,
    // line result
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_scl_out,
    output logic                             m_sda_out,
    output logic                             m_sda_drive_enable,
    output logic                             m_busy_res,
    output logic                             m_op_done,
    output logic [7:0]                       m_read_data,
    output logic                             m_ack_missing
);
    import i2cbs_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t core_result, out_result;
    logic    in_fire;

    assign in_fire = s_valid & s_ready;

    always_comb begin
        item.command        = s_command;
        item.data_byte      = s_data_byte;
        item.ack_after_read = s_ack_after_read;
        item.sda_sample     = s_sda_sample;
    end

    i2cbs_cfg_regs u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .cfg            (cfg)
    );

    i2cbs_seq_core #(
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_fire (in_fire),
        .item      (item),
        .result    (core_result)
    );

    i2cbs_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_fire),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_scl_out          = out_result.scl_out;
    assign m_sda_out          = out_result.sda_out;
    assign m_sda_drive_enable = out_result.sda_drive_enable;
    assign m_busy_res         = out_result.busy_res;
    assign m_op_done          = out_result.op_done;
    assign m_read_data        = out_result.read_data;
    assign m_ack_missing      = out_result.ack_missing;

    // Input is only held off when a result is waiting in the output register
    `I2CBS_ASSERT_CLK(a_ready_low_needs_output, !s_ready |-> m_valid, "s_ready low with empty output")
    // A finishing operation leaves the sequencer idle
    `I2CBS_ASSERT_CLK(a_done_not_busy, (m_valid && m_op_done) |-> !m_busy_res, "done while busy")
    // A full skid entry stays full until the output is taken
    `I2CBS_ASSERT_CLK(a_skid_holds, (!s_ready && !m_ready) |=> !s_ready, "skid entry lost")

endmodule

>>> verif/i2c_master_bit_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit_tb;

    import i2cbs_pkg::*;

    localparam int          ClkPeriod   = 10;
    localparam int unsigned RandomTicks = 500;

    // Bus sequencer steps as tracked by the line predictor
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_HOLD,
        PH_START_LOW,
        PH_STOP_SETUP,
        PH_STOP_HOLD,
        PH_TX_SETUP,
        PH_TX_DATA,
        PH_TX_SCL_HIGH,
        PH_TX_SCL_LOW,
        PH_ACK_POLL,
        PH_RX_RELEASE,
        PH_RX_SCL_LOW,
        PH_RX_SCL_HIGH,
        PH_MACK_SCL_LOW,
        PH_MACK_DATA,
        PH_MACK_SCL_HIGH
    } seq_phase_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_write_en   = 1'b0;
    logic [CfgIndexW-1:0] cfg_index      = '0;
    logic [CfgDataW-1:0]  cfg_write_data = '0;

    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [2:0] s_command        = CMD_NONE;
    logic [7:0] s_data_byte      = '0;
    logic       s_ack_after_read = 1'b0;
    logic       s_sda_sample     = 1'b1;

    logic       m_valid;
    logic       m_ready = 1'b1;
    logic       m_scl_out;
    logic       m_sda_out;
    logic       m_sda_drive_enable;
    logic       m_busy_res;
    logic       m_op_done;
    logic [7:0] m_read_data;
    logic       m_ack_missing;

    i2c_master_bit_sequencer_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_data_byte        (s_data_byte),
        .s_ack_after_read   (s_ack_after_read),
        .s_sda_sample       (s_sda_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_scl_out          (m_scl_out),
        .m_sda_out          (m_sda_out),
        .m_sda_drive_enable (m_sda_drive_enable),
        .m_busy_res         (m_busy_res),
        .m_op_done          (m_op_done),
        .m_read_data        (m_read_data),
        .m_ack_missing      (m_ack_missing)
    );

    // Clock
    initial begin
        forever #(ClkPeriod / 2) aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("[i2c_master_bit_sequencer_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Line predictor state
    // ------------------------------------------------------------------
    logic [15:0] cfg_tpd;
    logic [7:0]  cfg_dev_addr;
    logic [7:0]  cfg_wiper_addr;
    logic [7:0]  cfg_timeout;

    seq_phase_t  seq_phase;
    logic [15:0] unit_cnt;
    logic [1:0]  units_rem;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [7:0]  ack_wait;
    logic [1:0]  wiper_idx;
    logic [7:0]  rx_byte;
    logic        ack_err;
    logic        scl_q, sda_q, drv_q;
    command_t    active_cmd;
    logic [7:0]  wiper_val;
    logic        done_q;
    logic        sda_in;

    result_t     line_expect_q[$];

    // Bookkeeping
    int          failures     = 0;
    int unsigned ticks_sent   = 0;
    int unsigned ack_timeouts = 0;
    int unsigned launched[8];
    bit          tx_idling    = 1'b1;
    bit          rx_idling    = 1'b1;
    int unsigned rx_hold      = 0;

    // Slave responder state
    seq_phase_t  prev_phase;
    int          poll_idx;
    int          nack_at;
    int unsigned ack_pct;
    bit          slave_acking;

    function automatic void reset_line_model();
        cfg_tpd        = TicksPerDelayRst;
        cfg_dev_addr   = '0;
        cfg_wiper_addr = '0;
        cfg_timeout    = AckTimeoutRst;
        seq_phase      = PH_IDLE;
        unit_cnt       = '0;
        units_rem      = '0;
        bit_cnt        = '0;
        shifter        = '0;
        ack_wait       = '0;
        wiper_idx      = '0;
        rx_byte        = '0;
        ack_err        = 1'b0;
        scl_q          = 1'b1;
        sda_q          = 1'b1;
        drv_q          = 1'b1;
        active_cmd     = CMD_NONE;
        wiper_val      = '0;
        done_q         = 1'b0;
        sda_in         = 1'b0;
    endfunction

    function automatic void apply_cfg(input cfg_reg_t idx, input logic [15:0] val);
        case (idx)
            REG_TICKS_PER_DELAY: cfg_tpd        = val;
            REG_DEVICE_ADDR:     cfg_dev_addr   = val[7:0];
            REG_WIPER_ADDR:      cfg_wiper_addr = val[7:0];
            REG_ACK_TIMEOUT:     cfg_timeout    = val[7:0];
            default: ;
        endcase
    endfunction

    // Step of k units: k-1 extra unit expiries before the step ends
    function automatic void arm_units(input int units);
        unit_cnt  = '0;
        units_rem = 2'(units - 1);
    endfunction

    function automatic void finish_op();
        seq_phase  = PH_IDLE;
        active_cmd = CMD_NONE;
        done_q     = 1'b1;
    endfunction

    // Line changes applied on the tick a step is entered
    function automatic void enter_phase(input seq_phase_t p);
        seq_phase = p;
        case (p)
            PH_START_HOLD: begin
                drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; arm_units(3);
            end
            PH_START_LOW:  begin sda_q = 1'b0; arm_units(1); end
            PH_STOP_SETUP: begin drv_q = 1'b1; sda_q = 1'b0; arm_units(1); end
            PH_STOP_HOLD:  begin scl_q = 1'b1; arm_units(3); end
            PH_TX_SETUP:   begin drv_q = 1'b1; scl_q = 1'b0; bit_cnt = '0; arm_units(1); end
            PH_TX_DATA: begin
                sda_q   = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                arm_units(1);
            end
            PH_TX_SCL_HIGH: begin scl_q = 1'b1; arm_units(1); end
            PH_TX_SCL_LOW:  begin scl_q = 1'b0; arm_units(1); end
            PH_ACK_POLL: begin
                drv_q    = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
                ack_wait = '0;
                ack_err  = 1'b0;
                arm_units(1);
            end
            PH_RX_RELEASE: begin drv_q = 1'b0; bit_cnt = '0; shifter = '0; arm_units(1); end
            PH_RX_SCL_LOW: begin scl_q = 1'b0; arm_units(1); end
            PH_RX_SCL_HIGH: begin
                scl_q   = 1'b1;
                shifter = {shifter[6:0], sda_in};
                arm_units(1);
            end
            PH_MACK_SCL_LOW:  begin scl_q = 1'b0; drv_q = 1'b1; arm_units(1); end
            PH_MACK_DATA:     begin sda_q = ~ack_wait[0]; arm_units(1); end
            PH_MACK_SCL_HIGH: begin scl_q = 1'b1; arm_units(1); end
            default: seq_phase = PH_IDLE;
        endcase
    endfunction

    // Address bytes are fetched from the registers as each byte begins
    function automatic void load_wiper_byte();
        if (wiper_idx == 2'd0)      shifter = cfg_dev_addr;
        else if (wiper_idx == 2'd1) shifter = cfg_wiper_addr;
        else                        shifter = wiper_val;
        enter_phase(PH_TX_SETUP);
    endfunction

    function automatic void byte_acked();
        if (active_cmd == CMD_WIPER) begin
            if (wiper_idx < 2'd2) begin
                wiper_idx = wiper_idx + 2'd1;
                load_wiper_byte();
            end else begin
                enter_phase(PH_STOP_SETUP);
            end
        end else begin
            finish_op();
        end
    endfunction

    function automatic void expire_step();
        case (seq_phase)
            PH_START_HOLD: enter_phase(PH_START_LOW);
            PH_START_LOW: begin
                scl_q = 1'b0;
                if (active_cmd == CMD_WIPER) begin
                    wiper_idx = '0;
                    load_wiper_byte();
                end else begin
                    finish_op();
                end
            end
            PH_STOP_SETUP:  enter_phase(PH_STOP_HOLD);
            PH_STOP_HOLD:   begin sda_q = 1'b1; finish_op(); end
            PH_TX_SETUP:    enter_phase(PH_TX_DATA);
            PH_TX_DATA:     enter_phase(PH_TX_SCL_HIGH);
            PH_TX_SCL_HIGH: enter_phase(PH_TX_SCL_LOW);
            PH_TX_SCL_LOW: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) enter_phase(PH_ACK_POLL);
                else                 enter_phase(PH_TX_DATA);
            end
            PH_ACK_POLL: begin
                if (!sda_in) begin
                    scl_q = 1'b0;
                    byte_acked();
                end else if (ack_wait >= cfg_timeout) begin
                    // missing acknowledge: flag it and close with a stop
                    ack_err    = 1'b1;
                    active_cmd = CMD_STOP;
                    ack_timeouts++;
                    enter_phase(PH_STOP_SETUP);
                end else begin
                    ack_wait = ack_wait + 8'd1;
                    arm_units(1);
                end
            end
            PH_RX_RELEASE:  enter_phase(PH_RX_SCL_LOW);
            PH_RX_SCL_LOW:  enter_phase(PH_RX_SCL_HIGH);
            PH_RX_SCL_HIGH: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) enter_phase(PH_MACK_SCL_LOW);
                else                 enter_phase(PH_RX_SCL_LOW);
            end
            PH_MACK_SCL_LOW: enter_phase(PH_MACK_DATA);
            PH_MACK_DATA:    enter_phase(PH_MACK_SCL_HIGH);
            PH_MACK_SCL_HIGH: begin
                scl_q   = 1'b0;
                rx_byte = shifter;
                finish_op();
            end
            default: seq_phase = PH_IDLE;
        endcase
    endfunction

    // Advance the predictor by one tick and return the line levels after it
    function automatic result_t predict_line_tick(input item_t it);
        logic [15:0] tpd;
        result_t     res;
        sda_in = it.sda_sample;
        done_q = 1'b0;
        tpd    = (cfg_tpd == 16'd0) ? 16'd1 : cfg_tpd;
        if (seq_phase != PH_IDLE) begin
            unit_cnt = unit_cnt + 16'd1;
            if (unit_cnt >= tpd) begin
                unit_cnt = '0;
                if (units_rem == 2'd0) expire_step();
                else                   units_rem = units_rem - 2'd1;
            end
        end else if (it.command >= CMD_START && it.command <= CMD_WIPER) begin
            active_cmd = command_t'(it.command);
            case (it.command)
                CMD_START, CMD_WIPER: begin
                    wiper_val = it.data_byte;
                    enter_phase(PH_START_HOLD);
                end
                CMD_STOP:  enter_phase(PH_STOP_SETUP);
                CMD_WRITE: begin
                    shifter = it.data_byte;
                    enter_phase(PH_TX_SETUP);
                end
                default: begin
                    ack_wait = {7'd0, it.ack_after_read};
                    enter_phase(PH_RX_RELEASE);
                end
            endcase
        end
        res.scl_out          = scl_q;
        res.sda_out          = sda_q;
        res.sda_drive_enable = drv_q;
        res.busy_res         = (seq_phase != PH_IDLE);
        res.op_done          = done_q;
        res.read_data        = rx_byte;
        res.ack_missing      = ack_err;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one
    function automatic int unsigned draw_gap(input bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Slave model: pulls SDA low during acknowledge polls it chooses to answer
    function automatic logic slave_sda();
        if (seq_phase == PH_ACK_POLL && prev_phase != PH_ACK_POLL) begin
            poll_idx++;
            slave_acking = (poll_idx != nack_at) && ($urandom_range(0, 99) < ack_pct);
        end
        prev_phase = seq_phase;
        if (seq_phase != PH_ACK_POLL) return 1'($urandom_range(0, 1));
        if (!slave_acking) return 1'b1;
        return ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
    endfunction

    // Tick sent while an operation runs: command and data should be ignored
    function automatic item_t busy_tick();
        item_t it;
        it.command        = 3'($urandom_range(0, 7));
        it.data_byte      = 8'($urandom);
        it.ack_after_read = 1'($urandom);
        it.sda_sample     = slave_sda();
        return it;
    endfunction

    task automatic send_tick(input item_t it);
        int unsigned gap;
        s_valid          <= 1'b1;
        s_command        <= it.command;
        s_data_byte      <= it.data_byte;
        s_ack_after_read <= it.ack_after_read;
        s_sda_sample     <= it.sda_sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        line_expect_q.push_back(predict_line_tick(it));
        ticks_sent++;
        gap = draw_gap(tx_idling);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender off until every expected result has arrived
    task automatic drain_results();
        if (s_valid) s_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge aclk);
    endtask

    // Let the running operation finish, then drain
    task automatic settle_results();
        while (seq_phase != PH_IDLE) send_tick(busy_tick());
        drain_results();
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= val;
        @(posedge aclk);
        apply_cfg(idx, val);
    endtask

    // Write all registers while idle; the byte registers get junk upper bits
    task automatic configure(input logic [15:0] tpd, input logic [7:0] dev,
                             input logic [7:0] wreg, input logic [7:0] tmo);
        settle_results();
        write_reg(REG_TICKS_PER_DELAY, tpd);
        write_reg(REG_DEVICE_ADDR, {8'($urandom_range(0, 255)), dev});
        write_reg(REG_WIPER_ADDR,  {8'($urandom_range(0, 255)), wreg});
        write_reg(REG_ACK_TIMEOUT, {8'($urandom_range(0, 255)), tmo});
        cfg_write_en <= 1'b0;
    endtask

    // Issue one command at idle and tick until the sequencer is idle again.
    // nack_poll picks the acknowledge poll the slave never answers (-1: none).
    task automatic run_op(input logic [2:0] cmd, input logic [7:0] data, input logic ackr,
                          input int nack_poll, input int unsigned ack_chance,
                          input int unsigned pause_odds);
        item_t it;
        it.command        = cmd;
        it.data_byte      = data;
        it.ack_after_read = ackr;
        it.sda_sample     = 1'($urandom_range(0, 1));
        poll_idx   = -1;
        nack_at    = nack_poll;
        ack_pct    = ack_chance;
        prev_phase = PH_IDLE;
        launched[cmd]++;
        send_tick(it);
        while (seq_phase != PH_IDLE) begin
            if (pause_odds != 0 && $urandom_range(1, pause_odds) == 1) drain_results();
            send_tick(busy_tick());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_hold <= draw_gap(rx_idling);
        end
    end

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : check_line_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_expect_q.size() == 0) begin
                $error("line result transfer with nothing expected");
                failures++;
            end else begin
                want = line_expect_q.pop_front();
                check_field("scl_out",          8'(want.scl_out),   8'(m_scl_out));
                check_field("sda_out",          8'(want.sda_out),   8'(m_sda_out));
                check_field("sda_drive_enable", 8'(want.sda_drive_enable),
                            8'(m_sda_drive_enable));
                check_field("busy_res",         8'(want.busy_res),  8'(m_busy_res));
                check_field("op_done",          8'(want.op_done),   8'(m_op_done));
                check_field("read_data",        want.read_data,     m_read_data);
                check_field("ack_missing",      8'(want.ack_missing), 8'(m_ack_missing));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Idle ticks, unknown commands, then a start and a stop at reset timing
    task automatic test_reset_timing();
        run_op(CMD_NONE, 8'hFF, 1'b1, -1, 100, 0);
        run_op(3'd6, 8'h00, 1'b0, -1, 100, 0);
        run_op(3'd7, 8'hFF, 1'b1, -1, 100, 0);
        run_op(CMD_START, 8'h5A, 1'b0, -1, 100, 0);
        run_op(CMD_STOP, 8'h00, 1'b1, -1, 100, 0);
    endtask

    // Zero prescale (acts as one), byte extremes, ACK and NACK reads, a paused write, a start and a stop
    task automatic test_single_ops();
        configure(16'd0, 8'hFF, 8'h00, 8'd3);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_op(CMD_WRITE, 8'h00, 1'b0, -1, 100, 0);
        run_op(CMD_WRITE, 8'hFF, 1'b1, -1, 100, 0);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        run_op(CMD_READ, 8'h00, 1'b1, -1, 100, 0);
        run_op(CMD_READ, 8'hFF, 1'b0, -1, 100, 0);
        // sender waits for every result before each tick after the first of this write
        run_op(CMD_WRITE, 8'hA5, 1'b0, -1, 100, 1);
        run_op(CMD_START, 8'h00, 1'b0, -1, 100, 0);
        run_op(CMD_STOP, 8'hFF, 1'b0, -1, 100, 0);
    endtask

    // Acknowledge timeout at both timeout extremes; the flag clears on the next check
    task automatic test_ack_timeouts();
        configure(16'd1, 8'h00, 8'hFF, 8'd0);
        run_op(CMD_WRITE, 8'h3C, 1'b0, 0, 100, 0);
        run_op(CMD_READ, 8'h00, 1'b1, -1, 100, 0);
        run_op(CMD_WRITE, 8'hC3, 1'b0, -1, 100, 0);
        configure(16'd1, 8'h00, 8'hFF, 8'd255);
        run_op(CMD_WRITE, 8'h81, 1'b1, 0, 100, 0);
        run_op(CMD_WRITE, 8'h7E, 1'b0, -1, 100, 0);
    endtask

    // Full wiper transfers, then aborts on a missing acknowledge mid-transaction
    task automatic test_wiper();
        configure(16'd1, 8'hFF, 8'h00, 8'd2);
        run_op(CMD_WIPER, 8'hFF, 1'b0, -1, 100, 0);
        configure(16'd2, 8'h00, 8'hFF, 8'd1);
        run_op(CMD_WIPER, 8'h00, 1'b1, -1, 100, 0);
        run_op(CMD_WIPER, 8'h96, 1'b0, 1, 100, 0);
        run_op(CMD_WIPER, 8'h69, 1'b0, 2, 100, 0);
        run_op(CMD_WIPER, 8'h0F, 1'b1, 0, 100, 0);
    endtask

    // Long prescale: a single stop, no idling so the run stays short
    task automatic test_slow_prescale();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        configure(16'd40, 8'hA5, 8'h5A, 8'd0);
        run_op(CMD_STOP, 8'hFF, 1'b1, -1, 100, 0);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned first_tick;
        int unsigned cfg_tick;
        int unsigned r;
        logic [15:0] tpd;
        logic [7:0]  tmo;
        logic [2:0]  cmd;
        int          nack;
        bit          fresh;
        first_tick = ticks_sent;
        cfg_tick   = ticks_sent;
        fresh      = 1'b1;
        while (ticks_sent - first_tick < RandomTicks) begin
            if (fresh || ticks_sent - cfg_tick >= 250) begin
                fresh = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 20)      tpd = 16'd0;
                else if (r < 70) tpd = 16'($urandom_range(1, 2));
                else if (r < 90) tpd = 16'($urandom_range(3, 6));
                else             tpd = 16'($urandom_range(7, 20));
                r = $urandom_range(0, 99);
                if (r < 50)      tmo = 8'($urandom_range(0, 4));
                else if (r < 88) tmo = 8'($urandom_range(5, 20));
                else begin
                    tmo = 8'd255;
                    tpd = 16'd1;
                end
                configure(tpd, 8'($urandom), 8'($urandom), tmo);
                cfg_tick  = ticks_sent;
                tx_idling = ($urandom_range(0, 3) != 0);
                rx_idling = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 88)      cmd = 3'($urandom_range(1, 5));
            else if (r < 94) cmd = 3'($urandom_range(6, 7));
            else             cmd = CMD_NONE;
            nack = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 3)) : -1;
            run_op(cmd, 8'($urandom), 1'($urandom), nack, 90, 400);
            repeat ($urandom_range(0, 3)) run_op(CMD_NONE, 8'($urandom), 1'($urandom),
                                                 -1, 90, 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_line_model();
        foreach (launched[i]) launched[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_timing();
        test_single_ops();
        test_ack_timeouts();
        test_wiper();
        test_slow_prescale();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d wiper,",
                 ticks_sent, launched[CMD_START], launched[CMD_STOP], launched[CMD_WRITE],
                 launched[CMD_READ], launched[CMD_WIPER]);
        $display("%0d idle or unknown commands, %0d acknowledge timeouts, prescale 0 to 40",
                 launched[0] + launched[6] + launched[7], ack_timeouts);
        if (failures == 0) begin
            $display("[i2c_master_bit_sequencer_unit] OK");
        end else begin
            $display("[i2c_master_bit_sequencer_unit] ERROR");
        end
        $finish;
    end

endmodule
